/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker module.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/boci_pkg.sv */
// Types and constants for the box overlap count index.
// Used by the top level and by its checker.
package boci_pkg;

   localparam int COORD_BITS      = 16;
   localparam int HIT_W           = 11;
   localparam int STATUS_W        = 2;
   localparam int FUNC_W          = 2;
   localparam int MAX_BOXES_DFLT  = 1024;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [COORD_BITS-1:0] x_low;
      logic [COORD_BITS-1:0] x_high;
      logic [COORD_BITS-1:0] y_low;
      logic [COORD_BITS-1:0] y_high;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_low;
      logic [COORD_BITS-1:0] x_high;
      logic [COORD_BITS-1:0] y_low;
      logic [COORD_BITS-1:0] y_high;
   } box_type;

   typedef struct packed {
      logic [HIT_W-1:0]    hit_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

/* hw/rtl/box_overlap_count_index.sv */
// Box overlap count index: top level with box, skip and stack memories.
// Depends on boci_pkg.
//
// Usage: one request on req_* (valid/stall) yields exactly one response on
// rsp_* (valid/stall). func add appends a box (status full when the table
// holds MAX_BOXES), build sorts the table by x start and fills the skip
// pointers, count returns the number of stored boxes overlapping the query.
// One request is worked at a time; req_stall stays high from acceptance until
// the response is taken. Build runs an insertion sort and then a stack scan;
// count runs a binary search and then walks the entries below the found position.
// Every step goes through one registered read port per memory.
// The response sits in an output register until rsp_stall is low.
// Reset empties the table and clears the built mark; memory contents are not
// cleared, as no request reads an entry that was never written.
module box_overlap_count_index #(
   parameter int MAX_BOXES = boci_pkg::MAX_BOXES_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  boci_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output boci_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam logic [CNT_W-1:0] NO_SKIP = CNT_W'(MAX_BOXES);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
   localparam logic [boci_pkg::HIT_W-1:0] HIT_ONE = {{(boci_pkg::HIT_W-1){1'b0}}, 1'b1};

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RSP    = 4'd1;
   localparam logic [3:0] ST_KEY    = 4'd2;
   localparam logic [3:0] ST_KEYW   = 4'd3;
   localparam logic [3:0] ST_CMP    = 4'd4;
   localparam logic [3:0] ST_CMPW   = 4'd5;
   localparam logic [3:0] ST_BKEY   = 4'd6;
   localparam logic [3:0] ST_BKEYW  = 4'd7;
   localparam logic [3:0] ST_BPOP   = 4'd8;
   localparam logic [3:0] ST_BPOPW  = 4'd9;
   localparam logic [3:0] ST_BENDW  = 4'd10;
   localparam logic [3:0] ST_SRCH   = 4'd11;
   localparam logic [3:0] ST_SRCHW  = 4'd12;
   localparam logic [3:0] ST_WALK   = 4'd13;
   localparam logic [3:0] ST_WALKW  = 4'd14;

   boci_pkg::box_type box_mem [MAX_BOXES];
   logic [CNT_W-1:0]  skip_mem [MAX_BOXES];
   logic [IDX_W-1:0]  stack_mem [MAX_BOXES];

   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    built_ff, built_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [CNT_W-1:0]        depth_ff, depth_in;
   logic [IDX_W-1:0]        top_ff, top_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;
   logic [boci_pkg::HIT_W-1:0] hits_ff, hits_in;
   boci_pkg::box_type       key_ff, key_in;
   boci_pkg::rsp_type       rsp_ff, rsp_in;

   boci_pkg::box_type box_rd_ff;
   logic [CNT_W-1:0]  skip_rd_ff;
   logic [IDX_W-1:0]  stack_rd_ff;

   logic [IDX_W-1:0]  box_rd_addr, box_wr_addr, skip_wr_addr, stack_rd_addr, stack_wr_addr;
   logic              box_we, skip_we, stack_we;
   boci_pkg::box_type box_wr_data;
   logic [CNT_W-1:0]  skip_wr_data;

   logic [CNT_W-1:0]  jm1, curm1, depm1;
   logic [CNT_W:0]    mid_sum;
   logic              goes_first, y_hit;

   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[box_wr_addr] <= box_wr_data;
      end
      if (skip_we) begin
         skip_mem[skip_wr_addr] <= skip_wr_data;
      end
      if (stack_we) begin
         stack_mem[stack_wr_addr] <= i_ff[IDX_W-1:0];
      end
      box_rd_ff   <= box_mem[box_rd_addr];
      skip_rd_ff  <= skip_mem[box_rd_addr];
      stack_rd_ff <= stack_mem[stack_rd_addr];
   end

   assign jm1     = j_ff - ONE;
   assign curm1   = i_ff - ONE;
   assign depm1   = depth_ff - ONE;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   assign goes_first = (key_ff.x_low != box_rd_ff.x_low) ? (key_ff.x_low < box_rd_ff.x_low)
                                                        : (key_ff.x_high > box_rd_ff.x_high);
   assign y_hit = !((box_rd_ff.y_low > key_ff.y_high) || (key_ff.y_low > box_rd_ff.y_high));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      built_in      = built_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      hits_in       = hits_ff;
      key_in        = key_ff;
      rsp_in        = rsp_ff;
      box_rd_addr   = i_ff[IDX_W-1:0];
      box_wr_addr   = j_ff[IDX_W-1:0];
      box_wr_data   = key_ff;
      box_we        = 1'b0;
      skip_wr_addr  = i_ff[IDX_W-1:0];
      skip_wr_data  = NO_SKIP;
      skip_we       = 1'b0;
      stack_rd_addr = depm1[IDX_W-1:0];
      stack_wr_addr = depth_ff[IDX_W-1:0];
      stack_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in  = '{x_low: req_data.x_low, x_high: req_data.x_high,
                           y_low: req_data.y_low, y_high: req_data.y_high};
               rsp_in  = '{hit_count: '0, status: boci_pkg::STAT_OK};
               hits_in = '0;
               unique case (req_data.func)
                  boci_pkg::FUNC_ADD: begin
                     built_in = 1'b0;
                     if (count_ff == NO_SKIP) begin
                        rsp_in.status = boci_pkg::STAT_FULL;
                     end else begin
                        box_we      = 1'b1;
                        box_wr_addr = count_ff[IDX_W-1:0];
                        box_wr_data = key_in;
                        count_in    = count_ff + ONE;
                     end
                     state_in = ST_RSP;
                  end
                  boci_pkg::FUNC_BUILD: begin
                     i_in     = ONE;
                     state_in = ST_KEY;
                  end
                  boci_pkg::FUNC_COUNT: begin
                     if (!built_ff) begin
                        rsp_in.status = boci_pkg::STAT_NOT_BUILT;
                        state_in      = ST_RSP;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = ST_SRCH;
                     end
                  end
                  default: begin
                     state_in = ST_RSP;
                  end
               endcase
            end
         end
         ST_RSP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         ST_KEY: begin
            if (i_ff >= count_ff) begin
               i_in     = '0;
               depth_in = '0;
               state_in = ST_BKEY;
            end else begin
               state_in = ST_KEYW;
            end
         end
         ST_KEYW: begin
            key_in   = box_rd_ff;
            j_in     = i_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            box_rd_addr = jm1[IDX_W-1:0];
            if (j_ff == '0) begin
               box_we   = 1'b1;
               i_in     = i_ff + ONE;
               state_in = ST_KEY;
            end else begin
               state_in = ST_CMPW;
            end
         end
         ST_CMPW: begin
            box_we = 1'b1;
            if (goes_first) begin
               box_wr_data = box_rd_ff;
               j_in        = jm1;
               state_in    = ST_CMP;
            end else begin
               i_in     = i_ff + ONE;
               state_in = ST_KEY;
            end
         end
         ST_BKEY: begin
            if (i_ff >= count_ff) begin
               built_in = 1'b1;
               rsp_in   = '{hit_count: '0, status: boci_pkg::STAT_OK};
               state_in = ST_RSP;
            end else begin
               state_in = ST_BKEYW;
            end
         end
         ST_BKEYW: begin
            key_in   = box_rd_ff;
            state_in = ST_BPOP;
         end
         ST_BPOP: begin
            if (depth_ff == '0) begin
               skip_we  = 1'b1;
               stack_we = 1'b1;
               depth_in = depth_ff + ONE;
               i_in     = i_ff + ONE;
               state_in = ST_BKEY;
            end else begin
               state_in = ST_BPOPW;
            end
         end
         ST_BPOPW: begin
            box_rd_addr = stack_rd_ff;
            top_in      = stack_rd_ff;
            state_in    = ST_BENDW;
         end
         ST_BENDW: begin
            if (box_rd_ff.x_high <= key_ff.x_high) begin
               depth_in = depm1;
               state_in = ST_BPOP;
            end else begin
               skip_we      = 1'b1;
               skip_wr_data = CNT_W'(top_ff);
               stack_we     = 1'b1;
               depth_in     = depth_ff + ONE;
               i_in         = i_ff + ONE;
               state_in     = ST_BKEY;
            end
         end
         ST_SRCH: begin
            mid_in      = mid_sum[CNT_W:1];
            box_rd_addr = mid_in[IDX_W-1:0];
            if (lo_ff < hi_ff) begin
               state_in = ST_SRCHW;
            end else begin
               i_in     = lo_ff;
               state_in = ST_WALK;
            end
         end
         ST_SRCHW: begin
            if (box_rd_ff.x_low <= key_ff.x_high) begin
               lo_in = mid_ff + ONE;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SRCH;
         end
         ST_WALK: begin
            box_rd_addr = curm1[IDX_W-1:0];
            if (i_ff == '0) begin
               rsp_in   = '{hit_count: hits_ff, status: boci_pkg::STAT_OK};
               state_in = ST_RSP;
            end else begin
               state_in = ST_WALKW;
            end
         end
         ST_WALKW: begin
            if (key_ff.x_low <= box_rd_ff.x_high) begin
               if (y_hit) begin
                  hits_in = hits_ff + HIT_ONE;
               end
               i_in = curm1;
            end else begin
               i_in = (skip_rd_ff < curm1) ? skip_rd_ff + ONE : '0;
            end
            state_in = ST_WALK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         built_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         built_ff <= built_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      depth_ff <= depth_in;
      top_ff   <= top_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      hits_ff  <= hits_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/boci_checker.sv */
// Port checker for the box overlap count index, bound to the top level.
// Depends on boci_pkg and assert_macros.svh.
`include "assert_macros.svh"

module boci_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input boci_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input boci_pkg::rsp_type rsp_data
);

   `AST_NXT(req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))
   `AST_NXT(rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `AST_IMP(busy_while_rsp, clock, reset, rsp_valid, req_stall)
   `AST_NXT(busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   `AST_IMP(err_no_hits, clock, reset, rsp_valid && (rsp_data.status != boci_pkg::STAT_OK), (rsp_data.hit_count == '0) && ((rsp_data.status == boci_pkg::STAT_FULL) || (rsp_data.status == boci_pkg::STAT_NOT_BUILT)))

endmodule

bind box_overlap_count_index boci_checker u_boci_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
